// ----- rtl/rea_pkg.sv -----
// ---------------------------------------------------------------------------
// rea_pkg
// Shared types and constants for the rectangle-ellipse aperture check.
// ---------------------------------------------------------------------------
`default_nettype none
package rea_pkg;

    localparam int POS_W     = 32;
    localparam int SIZE_W    = 23;
    localparam int FRAC_BITS = 16;
    localparam int T_W       = FRAC_BITS + 1;
    localparam int NUM_W     = POS_W + FRAC_BITS;
    localparam int IDX_W     = 6;
    localparam int CFG_W     = 7;
    localparam int NSIZE     = 4;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [1:0] V_INSIDE    = 2'd0;
    localparam logic [1:0] V_OUT_ELL   = 2'd1;
    localparam logic [1:0] V_OUT_RECT  = 2'd2;
    localparam logic [1:0] V_BEYOND    = 2'd3;

    // multiplier op sequence
    localparam logic [3:0] OP_BLEND_LAST = 4'd3;
    localparam logic [3:0] OP_SQ_X       = 4'd4;
    localparam logic [3:0] OP_SQ_B       = 4'd7;
    localparam logic [3:0] OP_P1         = 4'd8;
    localparam logic [3:0] OP_P2         = 4'd9;
    localparam logic [3:0] OP_P3         = 4'd10;

    // size order: rect width, rect height, ellipse h, ellipse v
    typedef struct packed {
        logic [NSIZE-1:0][SIZE_W-1:0] size;
        logic [POS_W-1:0]             pos;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_DIV,
        ST_MUL,
        ST_FINISH
    } state_t;

endpackage
`default_nettype wire

// ----- rtl/rea_ram.sv -----
// ---------------------------------------------------------------------------
// rea_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
`default_nettype none
module rea_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

// ----- rtl/rea_div.sv -----
// ---------------------------------------------------------------------------
// rea_div
// Restoring divider, one quotient bit per cycle, for the segment fraction.
// ---------------------------------------------------------------------------
`default_nettype none
module rea_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [rea_pkg::NUM_W-1:0]   num,
    input  wire logic [rea_pkg::POS_W-1:0]   den,
    output logic                             done,
    output logic      [rea_pkg::T_W-1:0]     quot
);
    import rea_pkg::*;

    localparam int CW = $clog2(NUM_W + 1);

    logic [POS_W-1:0] rem_reg;
    logic [NUM_W-1:0] num_reg;
    logic [T_W-1:0]   q_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [POS_W:0]   trial;
    logic             ge;

    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign ge    = trial >= {1'b0, den};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            num_reg <= num;
            q_reg   <= '0;
        end else if (busy_reg) begin
            rem_reg <= ge ? POS_W'(trial - {1'b0, den}) : trial[POS_W-1:0];
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            q_reg   <= {q_reg[T_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

    always_ff @(posedge aclk) begin
        if (aresetn) begin
            assert (!(start && busy_reg))
                else $error("divider restarted while busy");
        end
    end
endmodule
`default_nettype wire

// ----- rtl/rea_mul.sv -----
// ---------------------------------------------------------------------------
// rea_mul
// Shift-add multiplier, one multiplier bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module rea_mul #(
    parameter int MW = 48
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            start,
    input  wire logic [MW-1:0]   a,
    input  wire logic [MW-1:0]   b,
    output logic                 busy,
    output logic                 done,
    output logic      [2*MW-1:0] prod
);
    localparam int CW = $clog2(MW + 1);

    logic [2*MW-1:0] a_reg;
    logic [MW-1:0]   b_reg;
    logic [2*MW-1:0] acc_reg;
    logic [CW-1:0]   cnt_reg;
    logic            busy_reg;
    logic            done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(MW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= {{MW{1'b0}}, a};
            b_reg   <= b;
            acc_reg <= '0;
        end else if (busy_reg) begin
            acc_reg <= b_reg[0] ? acc_reg + a_reg : acc_reg;
            a_reg   <= {a_reg[2*MW-2:0], 1'b0};
            b_reg   <= {1'b0, b_reg[MW-1:1]};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign prod = acc_reg;

    always_ff @(posedge aclk) begin
        if (aresetn) begin
            assert (!(start && busy_reg))
                else $error("multiplier restarted while busy");
        end
    end
endmodule
`default_nettype wire

// ----- rtl/rect_ellipse_aperture_check_unit.sv -----
// ---------------------------------------------------------------------------
// rect_ellipse_aperture_check_unit
// Aperture table in RAM, linear interpolation and ellipse/rectangle test.
// ---------------------------------------------------------------------------
// Usage:
//   s_ channel: tuser = command (0 write entry, 1 query). A write word stores
//   one table entry and yields no result. A query word gives x, y, z and
//   yields one result word on the m_ channel (verdict, is_inside).
//   cfg_wr_en/cfg_wr_data set the number of loaded entries; write it only
//   while the unit is idle.
//   A query scans the table entries in order, one RAM read and one compare
//   for each entry. On a hit, the fraction divider runs when z lies inside
//   a rising segment, then 11 products run on the shared shift-add
//   multiplier (MW = max(2*TRANSVERSE_BITS, 46) bits wide), and the result
//   is loaded into the output register.
//   One query is in work at a time; s_tready is high only while idle.
//   The result sits in an output register; the next word is taken while it
//   waits. If the receiver stalls, a finished query waits in its last state.
//   Reset (aresetn low, synchronous) clears the control state and the entry
//   count; the table RAM keeps its contents and needs no clearing.
// ---------------------------------------------------------------------------
`default_nettype none
module rect_ellipse_aperture_check_unit #(
    parameter int TABLE_DEPTH     = 64,
    parameter int TRANSVERSE_BITS = 24
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    // config
    input  wire logic                       cfg_wr_en,
    input  wire logic [rea_pkg::CFG_W-1:0]  cfg_wr_data,   // entry_count
    // input words
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // entry_index, entry_position, entry_rect_half_width, entry_rect_half_height,
    // entry_ellipse_half_h, entry_ellipse_half_v, point_x, point_y, point_z
    input  wire logic [((162 + 2*TRANSVERSE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    input  wire logic                       s_tuser,       // command
    // result words
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic      [7:0]                 m_tdata        // verdict, is_inside
);
    import rea_pkg::*;

    localparam int TB   = TRANSVERSE_BITS;
    localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW   = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;
    localparam int MW   = (2*TB > 2*SIZE_W) ? 2*TB : 2*SIZE_W;
    localparam int CMPW = (TB > SIZE_W) ? TB : SIZE_W;
    localparam int O_X  = IDX_W + POS_W + NSIZE*SIZE_W;
    localparam int O_Y  = O_X + TB;
    localparam int O_Z  = O_Y + TB;

    // input fields
    logic [IDX_W-1:0]        f_index;
    entry_t                  f_entry;
    logic [TB-1:0]           f_x;
    logic [TB-1:0]           f_y;
    logic [POS_W-1:0]        f_z;

    assign f_index      = s_tdata[IDX_W-1:0];
    assign f_entry.pos  = s_tdata[IDX_W +: POS_W];
    assign f_entry.size = s_tdata[IDX_W + POS_W +: NSIZE*SIZE_W];
    assign f_x          = s_tdata[O_X +: TB];
    assign f_y          = s_tdata[O_Y +: TB];
    assign f_z          = s_tdata[O_Z +: POS_W];

    // state
    state_t             state_reg, state_next;
    logic [CFG_W-1:0]   count_reg;
    logic [CW-1:0]      count_eff;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [3:0]         op_reg, op_next;
    logic               mul_go_reg, mul_go_next;
    logic               m_valid_reg, m_valid_next;
    logic [1:0]         m_verdict_reg;
    logic [1:0]         verdict_reg, verdict_next;
    // divider start is a single pulse on entry to ST_DIV
    logic               div_fired_reg;

    // payload
    logic [TB-1:0]      x_reg, y_reg;
    logic [POS_W-1:0]   zc_reg;
    entry_t             back_reg, front_reg;
    logic [T_W-1:0]     t_reg;
    logic [SIZE_W-1:0]  blend_reg [NSIZE];
    logic [MW-1:0]      sq_reg [NSIZE];
    logic [2*MW-1:0]    p1_reg, p2_reg;

    // ram
    logic               ram_we, ram_re;
    entry_t             ram_q;

    // units
    logic               div_start, div_done;
    logic [T_W-1:0]     div_q;
    logic               mul_start, mul_busy, mul_done;
    logic [MW-1:0]      mul_a, mul_b;
    logic [2*MW-1:0]    mul_p;

    logic               s_acc;
    logic               load_out;
    logic [1:0]         k;
    logic [SIZE_W-1:0]  bk, fr, diff;
    logic               up;
    logic [SIZE_W-1:0]  shifted;
    logic [TB-1:0]      ax, ay;
    logic [2*MW:0]      lhs;
    logic               out_ell, out_rect;

    assign s_acc     = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign count_eff = (CW'(count_reg) > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                           : CW'(count_reg);
    assign ram_we = s_acc && (s_tuser == CMD_WRITE) &&
                    ({{(32-IDX_W){1'b0}}, f_index} < 32'(TABLE_DEPTH));
    assign ram_re = (state_reg == ST_READ);

    rea_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (AW'(f_index)),
        .wr_data (f_entry),
        .rd_en   (ram_re),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (ram_q)
    );

    rea_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     ({zc_reg - back_reg.pos, {FRAC_BITS{1'b0}}}),
        .den     (front_reg.pos - back_reg.pos),
        .done    (div_done),
        .quot    (div_q)
    );

    rea_mul #(.MW(MW)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .busy    (mul_busy),
        .done    (mul_done),
        .prod    (mul_p)
    );

    // operand selection for the shared multiplier
    assign k       = op_reg[1:0];
    assign bk      = back_reg.size[k];
    assign fr      = front_reg.size[k];
    assign up      = fr >= bk;
    assign diff    = up ? fr - bk : bk - fr;
    assign shifted = mul_p[FRAC_BITS +: SIZE_W];
    assign ax      = x_reg[TB-1] ? ~x_reg + 1'b1 : x_reg;
    assign ay      = y_reg[TB-1] ? ~y_reg + 1'b1 : y_reg;
    assign lhs     = {1'b0, p1_reg} + {1'b0, p2_reg};
    assign out_ell = lhs > {1'b0, mul_p};
    assign out_rect = (CMPW'(ax) > CMPW'(blend_reg[0])) ||
                      (CMPW'(ay) > CMPW'(blend_reg[1]));

    always_comb begin
        mul_a = MW'(diff);
        mul_b = MW'(t_reg);
        if (op_reg == OP_SQ_X) begin
            mul_a = MW'(ax);
            mul_b = MW'(ax);
        end else if (op_reg == OP_SQ_X + 4'd1) begin
            mul_a = MW'(ay);
            mul_b = MW'(ay);
        end else if (op_reg == OP_SQ_X + 4'd2) begin
            mul_a = MW'(blend_reg[2]);
            mul_b = MW'(blend_reg[2]);
        end else if (op_reg == OP_SQ_B) begin
            mul_a = MW'(blend_reg[3]);
            mul_b = MW'(blend_reg[3]);
        end else if (op_reg == OP_P1) begin
            mul_a = sq_reg[0];
            mul_b = sq_reg[3];
        end else if (op_reg == OP_P2) begin
            mul_a = sq_reg[1];
            mul_b = sq_reg[2];
        end else if (op_reg == OP_P3) begin
            mul_a = sq_reg[2];
            mul_b = sq_reg[3];
        end
    end

    // control
    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        op_next      = op_reg;
        mul_go_next  = 1'b0;
        verdict_next = verdict_reg;
        div_start    = 1'b0;
        mul_start    = 1'b0;
        load_out     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc && (s_tuser == CMD_QUERY)) begin
                    idx_next = '0;
                    if (count_eff < CW'(2)) begin
                        verdict_next = V_BEYOND;
                        state_next   = ST_FINISH;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if ((idx_reg != '0) && (ram_q.pos >= zc_reg)) begin
                    op_next = '0;
                    if (ram_q.pos <= back_reg.pos || zc_reg <= back_reg.pos) begin
                        mul_go_next = 1'b1;
                        state_next  = ST_MUL;
                    end else begin
                        state_next = ST_DIV;
                    end
                end else if (idx_reg + 1'b1 == count_eff) begin
                    verdict_next = V_BEYOND;
                    state_next   = ST_FINISH;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_DIV: begin
                div_start = !div_fired_reg;
                if (div_done) begin
                    mul_go_next = 1'b1;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL: begin
                mul_start = mul_go_reg;
                if (mul_done) begin
                    if (op_reg == OP_P3) begin
                        verdict_next = out_ell ? V_OUT_ELL :
                                       out_rect ? V_OUT_RECT : V_INSIDE;
                        state_next   = ST_FINISH;
                    end else begin
                        op_next     = op_reg + 4'd1;
                        mul_go_next = 1'b1;
                    end
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            op_reg        <= '0;
            mul_go_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
            verdict_reg   <= V_INSIDE;
            div_fired_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            op_reg        <= op_next;
            mul_go_reg    <= mul_go_next;
            m_valid_reg   <= m_valid_next;
            verdict_reg   <= verdict_next;
            div_fired_reg <= (state_reg == ST_DIV);
            if (cfg_wr_en) begin
                count_reg <= cfg_wr_data;
            end
        end
    end

    assign m_valid_next = (m_valid_reg && !m_tready) || load_out;

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            x_reg  <= f_x;
            y_reg  <= f_y;
            zc_reg <= f_z[POS_W-1] ? '0 : f_z;
        end
        if (state_reg == ST_CHECK) begin
            if (idx_reg != '0 && ram_q.pos >= zc_reg) begin
                front_reg <= ram_q;
                if (ram_q.pos <= back_reg.pos) begin
                    t_reg <= T_W'(1) << FRAC_BITS;
                end else begin
                    t_reg <= '0;
                end
            end else begin
                back_reg <= ram_q;
            end
        end
        if (div_done) begin
            t_reg <= div_q;
        end
        if (mul_done) begin
            if (op_reg <= OP_BLEND_LAST) begin
                blend_reg[k] <= up ? bk + shifted : bk - shifted;
            end else if (op_reg <= OP_SQ_B) begin
                sq_reg[k] <= mul_p[MW-1:0];
            end else if (op_reg == OP_P1) begin
                p1_reg <= mul_p;
            end else if (op_reg == OP_P2) begin
                p2_reg <= mul_p;
            end
        end
        if (load_out) begin
            m_verdict_reg <= verdict_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, (m_verdict_reg == V_INSIDE), m_verdict_reg};

    // assertions
    property p_div_once;
        @(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_fired_reg;
    endproperty
    assert property (p_div_once) else $error("divider started twice");

    property p_no_mul_in_div;
        @(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> !mul_busy;
    endproperty
    assert property (p_no_mul_in_div) else $error("multiplier busy during divide");

    property p_query_starts;
        @(posedge aclk) disable iff (!aresetn)
        (s_acc && s_tuser == CMD_QUERY) |=>
            (state_reg == ST_READ || state_reg == ST_FINISH);
    endproperty
    assert property (p_query_starts) else $error("query did not start");

    property p_no_load_over_full;
        @(posedge aclk) disable iff (!aresetn)
        load_out |-> (!m_valid_reg || m_tready);
    endproperty
    assert property (p_no_load_over_full) else $error("result overwritten");

endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for rect_ellipse_aperture_check_unit: table loads,
// entry-count settings and point queries, with results checked against an
// in-bench aperture predictor under random stalls on both channels.
// ---------------------------------------------------------------------------
`default_nettype none
module tb;
    import rea_pkg::*;

    localparam int DEPTH  = 64;
    localparam int TB     = 24;
    localparam int DATA_W = ((162 + 2*TB + 7) / 8) * 8;
    localparam int TOTAL_WORDS = 1550;
    localparam int CALM_AFTER  = 1400;

    typedef struct {
        logic            cmd;
        logic [5:0]      idx;
        logic [31:0]     pos;
        logic [22:0]     w, h, ea, eb;
        logic [TB-1:0]   x, y;
        logic [31:0]     z;
    } word_t;

    typedef struct {
        int         cfg;      // -1: leave entry count as is
        word_t      wd;
        bit         typed;
        logic [1:0] vexp;
    } row_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]  cfg_wr_data = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata = '0;
    logic              s_tuser = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [7:0]        m_tdata;

    rect_ellipse_aperture_check_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // mirror of the aperture table and entry count
    logic [31:0] ap_pos [DEPTH];
    logic [22:0] ap_w [DEPTH], ap_h [DEPTH], ap_ea [DEPTH], ap_eb [DEPTH];
    logic [6:0]  ap_count = '0;

    logic [1:0] verdict_q [$];
    int errs = 0;
    int words_sent = 0;
    int queries_sent = 0;
    int seen [4] = '{0, 0, 0, 0};
    bit calm = 1'b0;

    function automatic logic [63:0] interp(logic [22:0] back, logic [22:0] front,
                                           logic [16:0] t);
        if (front >= back)
            return 64'(back) + ((64'(front - back) * 64'(t)) >> FRAC_BITS);
        return 64'(back) - ((64'(back - front) * 64'(t)) >> FRAC_BITS);
    endfunction

    function automatic logic [1:0] aperture_verdict(logic [TB-1:0] x, logic [TB-1:0] y,
                                                   logic [31:0] z);
        int          cnt, n, hit;
        logic [31:0] zc, sb, sf;
        logic [16:0] t;
        logic [63:0] w, h, ea, eb;
        logic [TB-1:0] ax, ay;
        logic [127:0] x2, y2, a2, b2, lhs, rhs;
        cnt = (ap_count > DEPTH) ? DEPTH : ap_count;
        zc  = z[31] ? 32'd0 : z;
        hit = 0;
        for (n = 1; n < cnt; n++)
            if (hit == 0 && ap_pos[n] >= zc) hit = n;
        if (hit == 0) return V_BEYOND;
        sb = ap_pos[hit-1];
        sf = ap_pos[hit];
        if (sf <= sb)      t = 17'h10000;
        else if (zc <= sb) t = '0;
        else               t = 17'((64'(zc - sb) << FRAC_BITS) / 64'(sf - sb));
        w  = interp(ap_w[hit-1],  ap_w[hit],  t);
        h  = interp(ap_h[hit-1],  ap_h[hit],  t);
        ea = interp(ap_ea[hit-1], ap_ea[hit], t);
        eb = interp(ap_eb[hit-1], ap_eb[hit], t);
        ax = x[TB-1] ? (~x + 1'b1) : x;
        ay = y[TB-1] ? (~y + 1'b1) : y;
        x2 = 128'(ax) * 128'(ax);
        y2 = 128'(ay) * 128'(ay);
        a2 = 128'(ea) * 128'(ea);
        b2 = 128'(eb) * 128'(eb);
        lhs = x2 * b2 + y2 * a2;
        rhs = a2 * b2;
        if (lhs > rhs) return V_OUT_ELL;
        if (64'(ax) > w || 64'(ay) > h) return V_OUT_RECT;
        return V_INSIDE;
    endfunction

    // result side: random stall bursts
    int stall_left = 0;
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (!calm && aresetn && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 7);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (verdict_q.size() == 0) begin
                $error("unexpected result word: verdict %0d", m_tdata[1:0]);
                errs++;
            end else begin
                logic [1:0] v;
                v = verdict_q.pop_front();
                seen[m_tdata[1:0]]++;
                if (m_tdata[1:0] !== v) begin
                    $error("verdict: expected %0d, got %0d", v, m_tdata[1:0]);
                    errs++;
                end
                if (m_tdata[2] !== (v == V_INSIDE)) begin
                    $error("is_inside: expected %0d, got %0d", v == V_INSIDE, m_tdata[2]);
                    errs++;
                end
            end
        end
    end

    task automatic send_word(word_t wd, bit typed = 1'b0, logic [1:0] vexp = V_INSIDE);
        s_tvalid <= 1'b1;
        s_tuser  <= wd.cmd;
        s_tdata  <= DATA_W'({wd.z, wd.y, wd.x, wd.eb, wd.ea, wd.h, wd.w, wd.pos, wd.idx});
        do @(posedge aclk); while (!s_tready);
        words_sent++;
        if (wd.cmd == CMD_WRITE) begin
            ap_pos[wd.idx] = wd.pos;
            ap_w[wd.idx]   = wd.w;
            ap_h[wd.idx]   = wd.h;
            ap_ea[wd.idx]  = wd.ea;
            ap_eb[wd.idx]  = wd.eb;
        end else begin
            queries_sent++;
            verdict_q.push_back(typed ? vexp : aperture_verdict(wd.x, wd.y, wd.z));
        end
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    endtask

    // drain all results, let the unit settle, then write the entry count
    task automatic set_count(logic [6:0] v);
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        ap_count = v;
    endtask

    function automatic word_t wr(logic [5:0] i, logic [31:0] p, logic [22:0] w,
                                 logic [22:0] h, logic [22:0] a, logic [22:0] b);
        word_t wd;
        wd = '{CMD_WRITE, i, p, w, h, a, b, '0, '0, '0};
        return wd;
    endfunction

    function automatic word_t qry(logic [TB-1:0] x, logic [TB-1:0] y, logic [31:0] z);
        word_t wd;
        wd = '{CMD_QUERY, '0, '0, '0, '0, '0, '0, x, y, z};
        return wd;
    endfunction

    function automatic logic [TB-1:0] rand_coord(int lim);
        logic [TB-1:0] v;
        if ($urandom_range(0, 9) == 0) return TB'($urandom);
        v = TB'($urandom_range(0, lim));
        return $urandom_range(0, 1) ? (~v + 1'b1) : v;
    endfunction

    task automatic load_entries(int k);
        logic [31:0] p [$];
        logic [31:0] tmp;
        int smax, i, j;
        bit wide;
        smax = (1 << $urandom_range(4, 23)) - 1;
        wide = ($urandom_range(0, 3) == 0);
        tmp  = $urandom_range(0, 100000);
        for (i = 0; i < k; i++)
            p.push_back(wide ? $urandom : tmp + $urandom_range(0, 20000));
        p.sort();
        if ($urandom_range(0, 7) == 0 && k > 2) begin
            i = $urandom_range(0, k-1);
            j = $urandom_range(0, k-1);
            tmp = p[i]; p[i] = p[j]; p[j] = tmp;
        end
        for (i = 0; i < k; i++)
            send_word(wr(6'(i), p[i], 23'($urandom_range(0, smax)),
                23'($urandom_range(0, smax)), 23'($urandom_range(0, smax)),
                23'($urandom_range(0, smax))));
    endtask

    row_t rows [$];

    initial begin
        int i, k, nq, eff, lim;
        logic [31:0] lo, hi;
        word_t wd;

        // directed rows
        rows.push_back('{0,  qry('0, '0, '0), 1'b1, V_BEYOND});
        rows.push_back('{-1, wr(0, 32'd1000, 23'd5000, 23'd5000, 23'd5000, 23'd5000), 0, 0});
        rows.push_back('{-1, wr(1, 32'd2000, 23'h7FFFFF, 23'h7FFFFF, 23'd10000, 23'd10000),
                         0, 0});
        rows.push_back('{-1, wr(2, 32'd2000, 23'd100, 23'd100, 23'd0, 23'd100), 0, 0});
        rows.push_back('{-1, wr(3, 32'hFFFFFFFF, 23'h7FFFFF, 23'd0, 23'h7FFFFF, 23'h7FFFFF),
                         0, 0});
        rows.push_back('{1,  qry('0, '0, '0), 1'b1, V_BEYOND});
        rows.push_back('{4,  qry('0, '0, 32'hFFFFFFFB), 1'b1, V_INSIDE});
        rows.push_back('{-1, qry(24'h7FFFFF, '0, 32'd1500), 0, 0});
        rows.push_back('{-1, qry(24'h800000, 24'h800000, 32'd1500), 0, 0});
        rows.push_back('{-1, qry(24'd9000, 24'd9000, 32'd2000), 0, 0});
        rows.push_back('{-1, qry(24'd50, 24'd99, 32'd3000), 0, 0});
        rows.push_back('{-1, qry(24'd7000, 24'hFFF000, 32'h7FFFFFFF), 0, 0});
        rows.push_back('{-1, qry(24'd5000, 24'd5001, 32'd1000), 0, 0});
        rows.push_back('{3,  qry('0, '0, 32'd2500), 1'b1, V_BEYOND});
        // equal and reversed first segment
        rows.push_back('{-1, wr(0, 32'd2000, 23'd300, 23'd300, 23'd300, 23'd300), 0, 0});
        rows.push_back('{-1, qry(24'd400, '0, 32'd100), 0, 0});
        rows.push_back('{-1, wr(0, 32'd9000, 23'd300, 23'd300, 23'd300, 23'd300), 0, 0});
        rows.push_back('{-1, qry(24'd9999, 24'd20, 32'd1999), 0, 0});
        rows.push_back('{-1, qry('0, '0, 32'h80000000), 0, 0});

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[r]) begin
            if (rows[r].cfg >= 0) set_count(7'(rows[r].cfg));
            send_word(rows[r].wd, rows[r].typed, rows[r].vexp);
        end

        // every entry written before any count can reach it
        load_entries(DEPTH);
        set_count(7'(DEPTH));

        while (words_sent < TOTAL_WORDS) begin
            case ($urandom_range(0, 9))
                0: k = 0;
                1: k = 1;
                2: k = 2;
                3: k = 64;
                4: k = 127;
                5: k = $urandom_range(65, 127);
                default: k = $urandom_range(3, 63);
            endcase
            eff = (k > DEPTH) ? DEPTH : ((k < 2) ? 2 : k);
            load_entries(eff);
            set_count(7'(k));
            lo  = ap_pos[0];
            hi  = ap_pos[eff-1];
            if (lo > hi) begin lo = ap_pos[eff-1]; hi = ap_pos[0]; end
            lim = 0;
            for (i = 0; i < eff; i++) begin
                if (ap_w[i] > lim)  lim = ap_w[i];
                if (ap_eb[i] > lim) lim = ap_eb[i];
            end
            lim = lim + lim / 4 + 1;
            if (lim > 24'h7FFFFF) lim = 24'h7FFFFF;
            nq = $urandom_range(5, 40);
            for (i = 0; i < nq && words_sent < TOTAL_WORDS; i++) begin
                if (words_sent >= CALM_AFTER) calm = 1'b1;
                if ($urandom_range(0, 9) == 0) begin
                    wd = wr(6'($urandom), $urandom, 23'($urandom), 23'($urandom),
                            23'($urandom), 23'($urandom));
                end else begin
                    case ($urandom_range(0, 9))
                        0: wd = qry(rand_coord(lim), rand_coord(lim), 32'h80000000 | $urandom);
                        1, 2: wd = qry(rand_coord(lim), rand_coord(lim), $urandom);
                        default: wd = qry(rand_coord(lim), rand_coord(lim),
                                          $urandom_range(lo, hi));
                    endcase
                end
                send_word(wd);
            end
        end

        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        $display("covered %0d words, %0d of them queries", words_sent, queries_sent);
        $display("verdicts seen: inside %0d, ellipse %0d, rectangle %0d, beyond %0d",
                 seen[0], seen[1], seen[2], seen[3]);
        if (errs == 0)
            $display("rect_ellipse_aperture_check_unit: match");
        else
            $display("rect_ellipse_aperture_check_unit: mismatch");
        $finish;
    end

    initial begin
        #20000000;
        $display("rect_ellipse_aperture_check_unit: mismatch");
        $finish;
    end

endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/rea_pkg.sv
rtl/rea_ram.sv
rtl/rea_div.sv
rtl/rea_mul.sv
rtl/rect_ellipse_aperture_check_unit.sv
tb/sv/tb.sv
